// ===== src/ssc_pkg.sv =====
// Shared types and constants for the stack sortability checker.
// No dependencies; every other file imports this package.
package ssc_pkg;

	localparam int CAR_W = 11;

	typedef logic [CAR_W-1:0] car_t;

	// Sequencer states, one-hot.
	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_DRAIN  = 4'b0100,
		S_REPORT = 4'b1000
	} ssc_state_t;

	// Commands from the sequencer to the stack unit.
	typedef struct packed {
		logic push;
		logic pop;
	} stk_cmd_t;

endpackage

// ===== src/ssc_if.sv =====
// Valid/ready channels of the stack sortability checker: car requests in, verdicts out.
// Depends on ssc_pkg.
interface ssc_car_if import ssc_pkg::*; ();
	logic valid;
	logic ready;
	car_t car_number;
	logic last_car;

	modport source (output valid, output car_number, output last_car, input ready);
	modport sink (input valid, input car_number, input last_car, output ready);
endinterface

interface ssc_verdict_if;
	logic valid;
	logic ready;
	logic sortable;

	modport source (output valid, output sortable, input ready);
	modport sink (input valid, input sortable, output ready);
endinterface

// ===== src/stack_sortability_checker.sv =====
// Top level of the stack sortability checker: sequencer, counters and verdict.
// Depends on ssc_pkg, ssc_if and ssc_stack.
//
//  Channel   Dir  Handshake      Payload
//  cars      in   valid/ready    car_number[10:0], last_car
//  verdict   out  valid/ready    sortable (one per sequence, after the last car)
//
// A car request is accepted in S_IDLE; S_SCAN then pops each car on top that is
// smaller than it and pushes it if there is room. After the last car, S_DRAIN
// pops the cars left on the stack until it sees the stack empty, and S_REPORT
// presents the verdict. The stack, doing one push or pop per cycle, sets this pace.
// arst_n clears the sequencer and counters; the stack memory is not cleared. The block is
// not ready while a request is worked on, and the verdict holds until it is taken.
module stack_sortability_checker import ssc_pkg::*; #(
	parameter int MAX_CARS = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	ssc_car_if.sink               cars,
	ssc_verdict_if.source         verdict
);

	localparam int ADDR_W = $clog2(MAX_CARS);
	localparam int CNT_W  = $clog2(MAX_CARS + 1);
	localparam int CMP_W  = (CNT_W + 1 > CAR_W) ? CNT_W + 1 : CAR_W;

	ssc_state_t       state_q;
	car_t             car_q;
	logic             last_q;
	logic [CNT_W-1:0] depth_q;
	logic [CNT_W-1:0] lane_q;
	logic             ok_q;

	car_t             top;
	stk_cmd_t         cmd;
	logic             stack_nonempty;
	logic             pop_hit;
	logic             room;
	logic             check_fail;
	logic [CNT_W:0]   fill;
	logic [CNT_W-1:0] below_top;

	assign stack_nonempty = (depth_q != '0);
	assign pop_hit        = stack_nonempty && (top < car_q);
	assign fill           = {1'b0, depth_q} + {1'b0, lane_q};
	assign room           = fill < (CNT_W + 1)'(MAX_CARS);
	assign below_top      = depth_q - CNT_W'(2);

	// A car entering the lane at position p must not exceed p + 1.
	assign check_fail = CMP_W'(top) > CMP_W'({1'b0, lane_q} + (CNT_W + 1)'(1));

	always_comb begin
		cmd.push = (state_q == S_SCAN) && !pop_hit && room;
		cmd.pop  = ((state_q == S_SCAN) && pop_hit) ||
		           ((state_q == S_DRAIN) && stack_nonempty);
	end

	ssc_stack #(
		.MAX_CARS (MAX_CARS),
		.ADDR_W   (ADDR_W)
	) u_stack (
		.clk     (clk),
		.cmd     (cmd),
		.wr_addr (depth_q[ADDR_W-1:0]),
		.rd_addr (below_top[ADDR_W-1:0]),
		.wr_data (car_q),
		.top     (top)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			depth_q <= '0;
			lane_q  <= '0;
			ok_q    <= 1'b1;
		end else begin
			if (cmd.pop) begin
				depth_q <= depth_q - CNT_W'(1);
				lane_q  <= lane_q + CNT_W'(1);
				if (check_fail) begin
					ok_q <= 1'b0;
				end
			end
			case (state_q)
				S_IDLE: begin
					if (cars.valid) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!pop_hit) begin
						if (room) begin
							depth_q <= depth_q + CNT_W'(1);
						end else begin
							// Stack and lane are full: the car is dropped.
							ok_q <= 1'b0;
						end
						state_q <= last_q ? S_DRAIN : S_IDLE;
					end
				end
				S_DRAIN: begin
					if (!stack_nonempty) begin
						state_q <= S_REPORT;
					end
				end
				S_REPORT: begin
					if (verdict.ready) begin
						depth_q <= '0;
						lane_q  <= '0;
						ok_q    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cars.valid && cars.ready) begin
			car_q  <= cars.car_number;
			last_q <= cars.last_car;
		end
	end

	assign cars.ready       = (state_q == S_IDLE);
	assign verdict.valid    = (state_q == S_REPORT);
	assign verdict.sortable = ok_q;

endmodule

// ===== src/ssc_stack.sv =====
// Side stack storage: one-port-write, one-port-read memory plus the top-of-stack register.
// Depends on ssc_pkg.
module ssc_stack import ssc_pkg::*; #(
	parameter int MAX_CARS = 1024,
	parameter int ADDR_W = $clog2(MAX_CARS)
) (
	input  logic              clk,
	input  stk_cmd_t          cmd,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [ADDR_W-1:0] rd_addr,
	input  car_t              wr_data,
	output car_t              top
);

	car_t mem [MAX_CARS];
	car_t top_q;

	// The top register doubles as the registered read port. A push puts the
	// new car there directly; a pop fetches the entry just below the old top.
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[wr_addr] <= wr_data;
			top_q <= wr_data;
		end else if (cmd.pop) begin
			top_q <= mem[rd_addr];
		end
	end

	assign top = top_q;

endmodule
